@@ hw/rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet decode for the Base64 stream
// decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Character codes with special meaning
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_PAD     = 8'h3d;

    // Job queue depth and pointer widths
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One job: one to three results for the back end to hand out
    typedef struct packed {
        logic [1:0]      last_idx;   // index of the final result (0..2)
        logic [2:0][7:0] bytes;      // result bytes, index 0 first
        logic            bad_char;   // error result
        logic            at_padding; // results of the '=' flush
    } t_job;

    // Sextet lookup: bit 6 is the hit flag, bits 5:0 the value
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = {1'b1, 6'(c - 8'd65)};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r = {1'b1, 6'(c - 8'd71)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c + 8'd4)};
        end else if (c == 8'h2b) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2f) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    // Byte assembly from sextets
    function automatic logic [7:0] first_byte(input logic [5:0] s0, input logic [5:0] s1);
        return {s0, s1[5:4]};
    endfunction

    function automatic logic [7:0] second_byte(input logic [5:0] s1, input logic [5:0] s2);
        return {s1[3:0], s2[5:2]};
    endfunction

    function automatic logic [7:0] third_byte(input logic [5:0] s2, input logic [5:0] s3);
        return {s2[1:0], s3};
    endfunction

endpackage

@@ hw/rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, collects sextets into groups and
// pushes finished jobs into the job queue.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_char,
    output logic           o_ready,
    input  logic           i_queue_full,
    output logic           o_push,
    output b64d_pkg::t_job o_job
);
    import b64d_pkg::*;

    logic [1:0]      r_fill, n_fill;
    logic [2:0][5:0] r_held, n_held;
    logic            r_halted, n_halted;
    logic [6:0]      w_sx;
    logic            w_take;

    assign o_ready = !i_queue_full;
    assign w_take  = i_valid && !i_queue_full && !r_halted;
    assign w_sx    = sextet_of(i_char);

    // Classification and group tracking
    always_comb begin
        n_fill   = r_fill;
        n_held   = r_held;
        n_halted = r_halted;
        o_push   = 1'b0;
        o_job    = '0;
        if (w_take && i_char != CHAR_NEWLINE) begin
            if (i_char == CHAR_PAD) begin
                n_halted         = 1'b1;
                o_job.at_padding = 1'b1;
                o_job.bytes[0]   = first_byte(r_held[0], r_held[1]);
                o_job.bytes[1]   = second_byte(r_held[1], r_held[2]);
                o_job.last_idx   = (r_fill == 2'd3) ? 2'd1 : 2'd0;
                o_push           = r_fill[1];
            end else if (!w_sx[6]) begin
                // not in the alphabet: single error result
                n_halted       = 1'b1;
                o_job.bad_char = 1'b1;
                o_push         = 1'b1;
            end else if (r_fill != 2'd3) begin
                n_held[r_fill] = w_sx[5:0];
                n_fill         = r_fill + 2'd1;
            end else begin
                // fourth sextet completes the group
                o_job.bytes[0] = first_byte(r_held[0], r_held[1]);
                o_job.bytes[1] = second_byte(r_held[1], r_held[2]);
                o_job.bytes[2] = third_byte(r_held[2], w_sx[5:0]);
                o_job.last_idx = 2'd2;
                o_push         = 1'b1;
                n_fill         = 2'd0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= 2'd0;
            r_held   <= '0;
            r_halted <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_held   <= n_held;
            r_halted <= n_halted;
        end
    end

endmodule

@@ hw/rtl/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output b64d_pkg::t_job o_job
);
    import b64d_pkg::*;

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Takes jobs from the queue and hands out their results one per cycle
// through an output register while downstream is ready (i_ready).
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  b64d_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last,
    output logic           o_bad_char,
    output logic           o_at_padding
);
    import b64d_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last, r_bad, r_pad;
    logic       w_load, w_fire, w_end;

    assign w_load = !r_valid || i_ready;
    assign w_fire = w_load && i_job_valid;
    assign w_end  = (r_idx == i_job.last_idx);
    assign o_pop  = w_fire && w_end;

    // Result index within the current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (w_fire) begin
            r_idx <= w_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_byte <= i_job.bytes[r_idx];
            r_last <= w_end;
            r_bad  <= i_job.bad_char;
            r_pad  <= i_job.at_padding;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_last       = r_last;
    assign o_bad_char   = r_bad;
    assign o_at_padding = r_pad;

endmodule

@@ hw/rtl/base64_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming Base64 decoder: one character in, decoded bytes out.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle in unless the job queue is full, one
//   result per cycle out while m_axis_tready is high.
// A job enters the queue at the transfer of the character that completes it;
//   the queue head then loads the output register once that register is free.
// A four-entry job queue lets the input run while results wait downstream.
// Reset (i_rst_n low, synchronous) empties the queue, clears the held group
//   and leaves the halted state.
module base64_stream_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [0] bad_char, [1] at_padding
);
    import b64d_pkg::*;

    logic w_full, w_push, w_pop, w_qvalid;
    t_job w_in_job, w_out_job;

    // Character classification and grouping
    b64d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_char       (s_axis_tdata),
        .o_ready      (s_axis_tready),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_job        (w_in_job)
    );

    // Job queue
    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_out_job)
    );

    // Result sequencing
    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_qvalid),
        .i_job        (w_out_job),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_bad_char   (m_axis_tuser[0]),
        .o_at_padding (m_axis_tuser[1])
    );

endmodule
